/* rtl/rrip_ab_pkg.sv */
// ----------------------------------------------------------------------------
// rrip_ab_pkg
// Shared widths, types and constants for the adaptive-bypass RRIP block.
// ----------------------------------------------------------------------------
package rrip_ab_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int SET_BITS       = $clog2(NUM_SETS);
    localparam int NUM_WAYS       = 16;
    localparam int WAY_BITS       = $clog2(NUM_WAYS);
    localparam int AGE_BITS       = 2;
    localparam int AGE_MAX        = (1 << AGE_BITS) - 1;
    localparam int ADAPT_INTERVAL = 128;
    localparam int ACC_BITS       = $clog2(ADAPT_INTERVAL);

    // fixed field widths of the channels
    localparam int SET_IDX_W  = 11;
    localparam int WAY_W      = 4;
    localparam int DRAW_W     = 7;
    localparam int HIT_W      = 8;
    localparam int PCT_W      = 7;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [HIT_W-1:0]   HIT_SAT            = 8'd255;
    localparam logic [PCT_W-1:0]   RST_INSERT_PERCENT = 7'd20;
    localparam logic [LIMIT_W-1:0] RST_LOW_HIT_LIMIT  = 8'd20;
    localparam logic [LIMIT_W-1:0] RST_HIGH_HIT_LIMIT = 8'd57;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INSERT_PERCENT = 2'd0,
        CFG_LOW_HIT_LIMIT  = 2'd1,
        CFG_HIGH_HIT_LIMIT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        MODE_FIND   = 1'b0,
        MODE_UPDATE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD
    } t_state;

    typedef logic [AGE_BITS-1:0] t_age;

    // one memory row holds the whole per-set state
    typedef struct packed {
        logic                   bypass;
        logic [HIT_W-1:0]       hits;
        logic [ACC_BITS-1:0]    accesses;
        logic [NUM_WAYS-1:0]    valid;
        t_age [NUM_WAYS-1:0]    ages;
    } t_set_row;

    localparam int ROW_W = $bits(t_set_row);

    // captured request, minus the set address
    typedef struct packed {
        t_mode               mode;
        logic [WAY_W-1:0]    way;
        logic                hit;
        logic [DRAW_W-1:0]   draw;
    } t_op;

    typedef struct packed {
        logic [PCT_W-1:0]   insert_percent;
        logic [LIMIT_W-1:0] low_hit_limit;
        logic [LIMIT_W-1:0] high_hit_limit;
    } t_cfg;

    function automatic t_set_row reset_row();
        t_set_row r;
        r = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            r.ages[w] = AGE_BITS'(AGE_MAX);
        end
        return r;
    endfunction

endpackage

/* rtl/rrip_ab_if.sv */
// ----------------------------------------------------------------------------
// rrip_ab_if
// Valid/ready channels: request, response and configuration write.
// ----------------------------------------------------------------------------
interface rrip_ab_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [rrip_ab_pkg::SET_IDX_W-1:0]   set_index;
    logic [rrip_ab_pkg::WAY_W-1:0]       way;
    logic                                hit;
    logic [rrip_ab_pkg::DRAW_W-1:0]      random_draw;

    modport source (output valid, mode, set_index, way, hit, random_draw, input ready);
    modport sink   (input valid, mode, set_index, way, hit, random_draw, output ready);
endinterface

interface rrip_ab_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rrip_ab_pkg::WAY_W-1:0]   victim_way;
    logic                            bypass_active;

    modport source (output valid, victim_way, bypass_active, input ready);
    modport sink   (input valid, victim_way, bypass_active, output ready);
endinterface

interface rrip_ab_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rrip_ab_pkg::CFG_IDX_W-1:0]    index;
    logic [rrip_ab_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rrip_ab_ram.sv */
// ----------------------------------------------------------------------------
// rrip_ab_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rrip_ab_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/rrip_ab_cfg.sv */
// ----------------------------------------------------------------------------
// rrip_ab_cfg
// Configuration register file: insert percentage and the two hit limits.
// ----------------------------------------------------------------------------
module rrip_ab_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rrip_ab_cfg_if.sink        i_cfg,
    output rrip_ab_pkg::t_cfg  o_cfg
);

    rrip_ab_pkg::t_cfg r_cfg;
    rrip_ab_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rrip_ab_pkg::CFG_INSERT_PERCENT: begin
                    n_cfg.insert_percent = i_cfg.data[rrip_ab_pkg::PCT_W-1:0];
                end
                rrip_ab_pkg::CFG_LOW_HIT_LIMIT: begin
                    n_cfg.low_hit_limit = i_cfg.data[rrip_ab_pkg::LIMIT_W-1:0];
                end
                rrip_ab_pkg::CFG_HIGH_HIT_LIMIT: begin
                    n_cfg.high_hit_limit = i_cfg.data[rrip_ab_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.insert_percent <= rrip_ab_pkg::RST_INSERT_PERCENT;
            r_cfg.low_hit_limit  <= rrip_ab_pkg::RST_LOW_HIT_LIMIT;
            r_cfg.high_hit_limit <= rrip_ab_pkg::RST_HIGH_HIT_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/rrip_ab_update.sv */
// ----------------------------------------------------------------------------
// rrip_ab_update
// Modify stage: victim search with aging, or age/valid/counter update on an
// access, applied to one set row read from memory.
// ----------------------------------------------------------------------------
module rrip_ab_update (
    input  rrip_ab_pkg::t_op                i_op, // request fields
    input  rrip_ab_pkg::t_set_row           i_row,
    input  rrip_ab_pkg::t_cfg               i_cfg,
    output rrip_ab_pkg::t_set_row           o_row,
    output logic [rrip_ab_pkg::WAY_W-1:0]   o_victim
);

    localparam rrip_ab_pkg::t_age AGE_TOP = rrip_ab_pkg::AGE_BITS'(rrip_ab_pkg::AGE_MAX);

    rrip_ab_pkg::t_op                              op;
    rrip_ab_pkg::t_age [rrip_ab_pkg::NUM_WAYS-1:0] age1;
    rrip_ab_pkg::t_age [rrip_ab_pkg::NUM_WAYS-1:0] age2;
    logic [rrip_ab_pkg::NUM_WAYS-1:0]              qual0;
    logic [rrip_ab_pkg::NUM_WAYS-1:0]              qual1;
    logic [rrip_ab_pkg::WAY_BITS-1:0]              pick0;
    logic [rrip_ab_pkg::WAY_BITS-1:0]              pick1;
    logic [rrip_ab_pkg::HIT_W-1:0]                 hits_inc;
    logic                                          way_ok;
    logic                                          insert;
    logic                                          wrap;

    assign op = i_op;

    // first scan, one aging, second scan, second aging
    always_comb begin
        for (int w = 0; w < rrip_ab_pkg::NUM_WAYS; w++) begin
            qual0[w] = !i_row.valid[w] || (i_row.ages[w] == AGE_TOP);
            age1[w]  = (i_row.ages[w] == AGE_TOP) ? i_row.ages[w] : i_row.ages[w] + 1'b1;
            qual1[w] = !i_row.valid[w] || (age1[w] == AGE_TOP);
            age2[w]  = (age1[w] == AGE_TOP) ? age1[w] : age1[w] + 1'b1;
        end
    end

    // lowest qualifying way wins
    always_comb begin
        pick0 = '0;
        pick1 = '0;
        for (int w = rrip_ab_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (qual0[w]) begin
                pick0 = rrip_ab_pkg::WAY_BITS'(w);
            end
            if (qual1[w]) begin
                pick1 = rrip_ab_pkg::WAY_BITS'(w);
            end
        end
    end

    assign way_ok   = int'(op.way) < rrip_ab_pkg::NUM_WAYS;
    assign hits_inc = (i_row.hits == rrip_ab_pkg::HIT_SAT) ? i_row.hits : i_row.hits + 1'b1;
    assign insert   = !i_row.bypass || (op.draw < i_cfg.insert_percent);
    assign wrap     = i_row.accesses == rrip_ab_pkg::ACC_BITS'(rrip_ab_pkg::ADAPT_INTERVAL - 1);

    always_comb begin
        o_row    = i_row;
        o_victim = '0;
        if (op.mode == rrip_ab_pkg::MODE_FIND) begin
            if (|qual0) begin
                o_victim = rrip_ab_pkg::WAY_W'(pick0);
            end else if (|qual1) begin
                o_victim   = rrip_ab_pkg::WAY_W'(pick1);
                o_row.ages = age1;
            end else begin
                o_row.ages = age2;
            end
        end else begin
            if (op.hit) begin
                o_row.hits = hits_inc;
                if (way_ok) begin
                    o_row.ages[op.way[rrip_ab_pkg::WAY_BITS-1:0]]  = '0;
                    o_row.valid[op.way[rrip_ab_pkg::WAY_BITS-1:0]] = 1'b1;
                end
            end else if (way_ok) begin
                o_row.ages[op.way[rrip_ab_pkg::WAY_BITS-1:0]]  = AGE_TOP;
                o_row.valid[op.way[rrip_ab_pkg::WAY_BITS-1:0]] = insert;
            end
            // end of interval: the hit count picks the mode, then clears
            if (wrap) begin
                if (o_row.hits < i_cfg.low_hit_limit) begin
                    o_row.bypass = 1'b1;
                end else if (o_row.hits > i_cfg.high_hit_limit) begin
                    o_row.bypass = 1'b0;
                end
                o_row.hits     = '0;
                o_row.accesses = '0;
            end else begin
                o_row.accesses = i_row.accesses + 1'b1;
            end
        end
    end

endmodule

/* rtl/rrip_replacement_adaptive_bypass.sv */
// ----------------------------------------------------------------------------
// rrip_replacement_adaptive_bypass
// Per-set 2-bit RRIP victim selection and update with adaptive bypass.
// ----------------------------------------------------------------------------
// Each request passes through S_IDLE and S_MOD: the transfer cycle reads the
// set's row from a single RAM (one row per set: ages, valid bits, interval
// counters, bypass flag), and S_MOD modifies the row, writes it back and loads
// the response register once that register is free. The RAM's registered read
// followed by the write back of the same row means a new request is taken
// only once the write back is done, even while the last response still waits.
// After reset, a clearing pass writes the reset row to all 2048 sets, one per
// cycle, and no request is taken during the pass; configuration writes are
// taken at any time and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module rrip_replacement_adaptive_bypass (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rrip_ab_req_if.sink    i_req,
    rrip_ab_rsp_if.source  o_rsp,
    rrip_ab_cfg_if.sink    i_cfg
);

    rrip_ab_pkg::t_state                   r_state;
    rrip_ab_pkg::t_state                   n_state;
    logic [rrip_ab_pkg::SET_BITS-1:0]      r_clr_addr;
    logic [rrip_ab_pkg::SET_BITS-1:0]      r_set;
    rrip_ab_pkg::t_op                      r_op;
    logic                                  r_out_valid;
    logic                                  n_out_valid;
    logic [rrip_ab_pkg::WAY_W-1:0]         r_victim;
    logic                                  r_bypass;

    rrip_ab_pkg::t_cfg                     cfg;
    rrip_ab_pkg::t_set_row                 rd_row;
    rrip_ab_pkg::t_set_row                 new_row;
    logic [rrip_ab_pkg::WAY_W-1:0]         victim;
    logic                                  req_take;
    logic                                  commit;
    logic                                  wr_en;
    logic [rrip_ab_pkg::SET_BITS-1:0]      wr_addr;
    logic [rrip_ab_pkg::ROW_W-1:0]         wr_data;

    rrip_ab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rrip_ab_ram #(
        .DEPTH (rrip_ab_pkg::NUM_SETS),
        .WIDTH (rrip_ab_pkg::ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (req_take),
        .i_rd_addr (i_req.set_index[rrip_ab_pkg::SET_BITS-1:0]),
        .o_rd_data (rd_row)
    );

    rrip_ab_update u_update (
        .i_op     (r_op),
        .i_row    (rd_row),
        .i_cfg    (cfg),
        .o_row    (new_row),
        .o_victim (victim)
    );

    assign i_req.ready = (r_state == rrip_ab_pkg::S_IDLE);
    assign req_take    = i_req.valid && i_req.ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_rsp.ready;
        commit      = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_set;
        wr_data     = new_row;
        unique case (r_state)
            rrip_ab_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = rrip_ab_pkg::reset_row();
                if (r_clr_addr == rrip_ab_pkg::SET_BITS'(rrip_ab_pkg::NUM_SETS - 1)) begin
                    n_state = rrip_ab_pkg::S_IDLE;
                end
            end
            rrip_ab_pkg::S_IDLE: begin
                if (req_take) begin
                    n_state = rrip_ab_pkg::S_MOD;
                end
            end
            rrip_ab_pkg::S_MOD: begin
                // hold the row until the response register frees up
                if (!r_out_valid || o_rsp.ready) begin
                    commit      = 1'b1;
                    wr_en       = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = rrip_ab_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrip_ab_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrip_ab_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == rrip_ab_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_set     <= i_req.set_index[rrip_ab_pkg::SET_BITS-1:0];
            r_op.mode <= rrip_ab_pkg::t_mode'(i_req.mode);
            r_op.way  <= i_req.way;
            r_op.hit  <= i_req.hit;
            r_op.draw <= i_req.random_draw;
        end
        if (commit) begin
            r_victim <= victim;
            r_bypass <= new_row.bypass;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.victim_way    = r_victim;
    assign o_rsp.bypass_active = r_bypass;

    // no request may slip in during the clearing pass
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrip_ab_pkg::S_CLEAR) |-> !req_take)
        else $error("request taken during clearing pass");

    // a response only appears right after a write back
    a_rsp_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(commit))
        else $error("response without write back");

    // every taken request is followed by the modify cycle
    a_take_then_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_state == rrip_ab_pkg::S_MOD))
        else $error("modify cycle missing after transfer");

    // update requests answer with way zero
    a_update_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_op.mode == rrip_ab_pkg::MODE_UPDATE)) |=> (o_rsp.victim_way == '0))
        else $error("nonzero victim on update");

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!r_out_valid || o_rsp.ready))
        else $error("response overwritten");

endmodule
